/* design/dq_pkg.sv */
// double-ended queue shared definitions: request codes and the request type
// no dependencies
package dq_pkg;

  // request code carried by one input item
  typedef logic [2:0] req_t;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_QUERY      = 3'd4;

endpackage

/* design/dq_ram.sv */
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/double_ended_queue.sv */
// double-ended queue top level: ring store control, end-value cache, result queue
// depends on dq_pkg and dq_ram
//
// A double-ended queue of signed VALUE_BITS-bit values held in a ring of
// CAPACITY entries in one synchronous RAM, with head and tail indices and a
// count in registers. Every request (push front, push back, pop front, pop
// back, query; unused codes act as a query) returns one item holding the popped
// value (-1 if none), the pop-empty and push-dropped flags, the count and the
// front and back values after the request (-1 when empty). A push into a full
// ring is dropped and flagged. The front and back values live in registers
// beside the RAM, so pushes, queries, failed pops and a pop of the last entry
// finish without a RAM read; a pop that leaves entries behind passes through
// the fetch state, where the registered RAM read brings the new end value. A
// two-entry output stage lets a new item in while a result still waits. The RAM
// needs no clearing after reset: only written entries are ever read.
module double_ended_queue #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            in_req_type,
  input  logic signed [VALUE_BITS-1:0]          in_push_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [VALUE_BITS-1:0]          out_popped_value,
  output logic                                  out_pop_was_empty,
  output logic                                  out_push_dropped,
  output logic [$clog2(CAPACITY+1)-1:0]         out_entry_count,
  output logic                                  out_is_empty,
  output logic signed [VALUE_BITS-1:0]          out_front_value,
  output logic signed [VALUE_BITS-1:0]          out_back_value
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0]      LAST_IDX   = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]      FULL_CNT   = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0]      ONE_CNT    = CNT_W'(1);
  localparam logic [VALUE_BITS-1:0] NONE_VALUE = '1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FETCH = 1'b1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] popped;
    logic                  pop_empty;
    logic                  dropped;
    logic [CNT_W-1:0]      count;
    logic                  empty;
    logic [VALUE_BITS-1:0] front;
    logic [VALUE_BITS-1:0] back;
  } result_t;

  // ring index helpers
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    idx_inc = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    idx_dec = (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

  // state registers
  logic                  state_r, state_nxt;
  logic [IDX_W-1:0]      front_idx_r, front_idx_nxt;
  logic [IDX_W-1:0]      back_idx_r, back_idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [VALUE_BITS-1:0] front_val_r, front_val_nxt;
  logic [VALUE_BITS-1:0] back_val_r, back_val_nxt;
  logic                  fetch_front_r, fetch_front_nxt;
  logic [VALUE_BITS-1:0] pend_popped_r, pend_popped_nxt;

  // output stage
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  // ram ports
  logic                  ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]      ram_wr_addr, ram_rd_addr;
  logic [VALUE_BITS-1:0] ram_wr_data, ram_rd_data;

  logic                  in_acc, out_take, done;
  logic [VALUE_BITS-1:0] popped_d;
  logic                  pop_empty_d, dropped_d;
  result_t               res_d;

  assign in_ready = (state_r == ST_IDLE) && !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;

  dq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // request decode, index update and ram access
  always_comb begin
    state_nxt       = state_r;
    front_idx_nxt   = front_idx_r;
    back_idx_nxt    = back_idx_r;
    count_nxt       = count_r;
    front_val_nxt   = front_val_r;
    back_val_nxt    = back_val_r;
    fetch_front_nxt = fetch_front_r;
    pend_popped_nxt = pend_popped_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = back_idx_r;
    ram_wr_data     = in_push_value;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = front_idx_r;
    done            = 1'b0;
    popped_d        = NONE_VALUE;
    pop_empty_d     = 1'b0;
    dropped_d       = 1'b0;

    if (state_r == ST_FETCH) begin
      // new end value arrives from the ram
      if (fetch_front_r) begin
        front_val_nxt = ram_rd_data;
      end else begin
        back_val_nxt = ram_rd_data;
      end
      popped_d  = pend_popped_r;
      done      = 1'b1;
      state_nxt = ST_IDLE;
    end else if (in_acc) begin
      case (in_req_type)
        dq_pkg::REQ_PUSH_FRONT: begin
          done = 1'b1;
          if (count_r == FULL_CNT) begin
            dropped_d = 1'b1;
          end else begin
            front_idx_nxt = idx_dec(front_idx_r);
            ram_wr_en     = 1'b1;
            ram_wr_addr   = idx_dec(front_idx_r);
            count_nxt     = count_r + ONE_CNT;
            front_val_nxt = in_push_value;
            if (count_r == '0) begin
              back_val_nxt = in_push_value;
            end
          end
        end
        dq_pkg::REQ_PUSH_BACK: begin
          done = 1'b1;
          if (count_r == FULL_CNT) begin
            dropped_d = 1'b1;
          end else begin
            back_idx_nxt = idx_inc(back_idx_r);
            ram_wr_en    = 1'b1;
            ram_wr_addr  = back_idx_r;
            count_nxt    = count_r + ONE_CNT;
            back_val_nxt = in_push_value;
            if (count_r == '0) begin
              front_val_nxt = in_push_value;
            end
          end
        end
        dq_pkg::REQ_POP_FRONT: begin
          if (count_r == '0) begin
            pop_empty_d = 1'b1;
            done        = 1'b1;
          end else begin
            popped_d      = front_val_r;
            front_idx_nxt = idx_inc(front_idx_r);
            count_nxt     = count_r - ONE_CNT;
            if (count_r == ONE_CNT) begin
              done = 1'b1;
            end else begin
              ram_rd_en       = 1'b1;
              ram_rd_addr     = idx_inc(front_idx_r);
              fetch_front_nxt = 1'b1;
              pend_popped_nxt = front_val_r;
              state_nxt       = ST_FETCH;
            end
          end
        end
        dq_pkg::REQ_POP_BACK: begin
          if (count_r == '0) begin
            pop_empty_d = 1'b1;
            done        = 1'b1;
          end else begin
            popped_d     = back_val_r;
            back_idx_nxt = idx_dec(back_idx_r);
            count_nxt    = count_r - ONE_CNT;
            if (count_r == ONE_CNT) begin
              done = 1'b1;
            end else begin
              ram_rd_en       = 1'b1;
              ram_rd_addr     = idx_dec(idx_dec(back_idx_r));
              fetch_front_nxt = 1'b0;
              pend_popped_nxt = back_val_r;
              state_nxt       = ST_FETCH;
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  // result item as the state stands after the request
  always_comb begin
    res_d.popped    = popped_d;
    res_d.pop_empty = pop_empty_d;
    res_d.dropped   = dropped_d;
    res_d.count     = count_nxt;
    res_d.empty     = (count_nxt == '0);
    res_d.front     = (count_nxt == '0) ? NONE_VALUE : front_val_nxt;
    res_d.back      = (count_nxt == '0) ? NONE_VALUE : back_val_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_idx_r <= '0;
      back_idx_r  <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      front_idx_r <= front_idx_nxt;
      back_idx_r  <= back_idx_nxt;
      count_r     <= count_nxt;
    end
  end

  // end-value cache and pending pop
  always_ff @(posedge clk) begin
    front_val_r   <= front_val_nxt;
    back_val_r    <= back_val_nxt;
    fetch_front_r <= fetch_front_nxt;
    pend_popped_r <= pend_popped_nxt;
  end

  // two-entry output stage; a result is only made while the skid slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= done;
      end else begin
        out_valid_r  <= done;
      end
    end else if (done) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res_d;
      end else begin
        out_r  <= res_d;
      end
    end else if (done) begin
      skid_r <= res_d;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_popped_value  = out_r.popped;
  assign out_pop_was_empty = out_r.pop_empty;
  assign out_push_dropped  = out_r.dropped;
  assign out_entry_count   = out_r.count;
  assign out_is_empty      = out_r.empty;
  assign out_front_value   = out_r.front;
  assign out_back_value    = out_r.back;

  // count never passes the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  // skid slot only holds an item behind a waiting output
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid item without output item");

  // count changes only in the cycle after an accepted item
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> $past(in_acc))
    else $error("count changed without an accepted item");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the double-ended queue: directed table, random phases,
// a ring predictor and a queue of predicted result items; depends on dq_pkg and double_ended_queue
module tb_top;

  localparam int CAPACITY     = 1024;
  localparam int VALUE_BITS   = 32;
  localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
  localparam int IDX_BITS     = $clog2(CAPACITY);
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [VALUE_BITS-1:0] NONE_MARK = -1;
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN   = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct {
    logic signed [VALUE_BITS-1:0] popped;
    logic                         pop_empty;
    logic                         dropped;
    logic [COUNT_BITS-1:0]        count;
    logic                         empty;
    logic signed [VALUE_BITS-1:0] front;
    logic signed [VALUE_BITS-1:0] back;
  } dq_result_t;

  typedef struct {
    dq_pkg::req_t                 req;
    logic signed [VALUE_BITS-1:0] val;
    bit                           fixed;
    dq_result_t                   res;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  dq_pkg::req_t                 in_req_type;
  logic signed [VALUE_BITS-1:0] in_push_value;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [VALUE_BITS-1:0] out_popped_value;
  logic                         out_pop_was_empty;
  logic                         out_push_dropped;
  logic [COUNT_BITS-1:0]        out_entry_count;
  logic                         out_is_empty;
  logic signed [VALUE_BITS-1:0] out_front_value;
  logic signed [VALUE_BITS-1:0] out_back_value;

  // predictor state: ring of values, end indices and fill count
  logic signed [VALUE_BITS-1:0] ring_vals [CAPACITY];
  logic [IDX_BITS-1:0]          head_idx = '0;
  logic [IDX_BITS-1:0]          tail_idx = '0;
  int                           fill_cnt = 0;

  dq_result_t pending_q [$];
  stim_row_t  dir_rows [$];
  int         errors     = 0;
  int         burst_left = 0;
  bit         no_gaps    = 1'b0;
  int         cycle_cnt  = 0;

  // receiver stall control
  int       hold_reqs  = 0;
  int       hold_taken = 0;
  int       hold_left  = 0;
  int       pat_left   = 0;
  rx_mode_t pat_mode   = RX_OPEN;

  double_ended_queue #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_pop_was_empty(out_pop_was_empty),
    .out_push_dropped (out_push_dropped),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value)
  );

  always #10 clk = ~clk;

  // apply one request to the ring predictor; index wrap is the natural
  // overflow of IDX_BITS since the capacity is a power of two
  task automatic dq_apply(input dq_pkg::req_t r, input logic signed [VALUE_BITS-1:0] v,
                          output dq_result_t res);
    res.popped    = NONE_MARK;
    res.pop_empty = 1'b0;
    res.dropped   = 1'b0;
    case (r)
      dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
        if (fill_cnt == CAPACITY) begin
          res.dropped = 1'b1;
        end else if (r == dq_pkg::REQ_PUSH_FRONT) begin
          head_idx = head_idx - 1'b1;
          ring_vals[head_idx] = v;
          fill_cnt++;
        end else begin
          ring_vals[tail_idx] = v;
          tail_idx = tail_idx + 1'b1;
          fill_cnt++;
        end
      end
      dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
        if (fill_cnt == 0) begin
          res.pop_empty = 1'b1;
        end else if (r == dq_pkg::REQ_POP_FRONT) begin
          res.popped = ring_vals[head_idx];
          head_idx = head_idx + 1'b1;
          fill_cnt--;
        end else begin
          tail_idx = tail_idx - 1'b1;
          res.popped = ring_vals[tail_idx];
          fill_cnt--;
        end
      end
      // query and unused codes leave the ring alone
      default: ;
    endcase
    res.count = fill_cnt[COUNT_BITS-1:0];
    res.empty = (fill_cnt == 0);
    if (fill_cnt == 0) begin
      res.front = NONE_MARK;
      res.back  = NONE_MARK;
    end else begin
      res.front = ring_vals[head_idx];
      res.back  = ring_vals[tail_idx - 1'b1];
    end
  endtask

  function automatic dq_result_t mk_res(input logic signed [VALUE_BITS-1:0] popped,
                                        input logic pe, input logic pd, input int cnt,
                                        input logic emp,
                                        input logic signed [VALUE_BITS-1:0] fr,
                                        input logic signed [VALUE_BITS-1:0] bk);
    dq_result_t r;
    r.popped    = popped;
    r.pop_empty = pe;
    r.dropped   = pd;
    r.count     = cnt[COUNT_BITS-1:0];
    r.empty     = emp;
    r.front     = fr;
    r.back      = bk;
    return r;
  endfunction

  task automatic add_row(input dq_pkg::req_t r, input logic signed [VALUE_BITS-1:0] v);
    stim_row_t row;
    row.req   = r;
    row.val   = v;
    row.fixed = 1'b0;
    row.res   = mk_res(NONE_MARK, 1'b0, 1'b0, 0, 1'b1, NONE_MARK, NONE_MARK);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_fixed(input dq_pkg::req_t r, input logic signed [VALUE_BITS-1:0] v,
                           input dq_result_t res);
    stim_row_t row;
    row.req   = r;
    row.val   = v;
    row.fixed = 1'b1;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // offer one item after an optional burst gap, then record its prediction
  task automatic send_row(input stim_row_t row);
    int         gap;
    dq_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_req_type   <= row.req;
    in_push_value <= row.val;
    do @(posedge clk); while (!in_ready);
    dq_apply(row.req, row.val, res);
    pending_q.insert(pending_q.size(), row.fixed ? row.res : res);
  endtask

  // random request with the given push and pop shares in percent
  task automatic send_rand(input int push_pct, input int pop_pct);
    stim_row_t row;
    int        pick;
    pick = $urandom_range(99);
    if (pick < push_pct) begin
      row.req = $urandom_range(1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT;
    end else if (pick < push_pct + pop_pct) begin
      row.req = $urandom_range(1) ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT;
    end else begin
      // query or one of the unused codes above it
      row.req = dq_pkg::REQ_QUERY + dq_pkg::req_t'($urandom_range(3));
    end
    row.val   = $urandom();
    row.fixed = 1'b0;
    row.res   = mk_res(NONE_MARK, 1'b0, 1'b0, 0, 1'b1, NONE_MARK, NONE_MARK);
    send_row(row);
  endtask

  // stop offering until every predicted item has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  // stimulus: reset, directed table, random phases, end of run
  initial begin : stimulus
    int k;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = dq_pkg::REQ_QUERY;
    in_push_value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue after reset, failed pops, unused code
    add_fixed(dq_pkg::REQ_QUERY, 32'sd0,
              mk_res(NONE_MARK, 1'b0, 1'b0, 0, 1'b1, NONE_MARK, NONE_MARK));
    add_fixed(dq_pkg::REQ_POP_FRONT, 32'sd5,
              mk_res(NONE_MARK, 1'b1, 1'b0, 0, 1'b1, NONE_MARK, NONE_MARK));
    add_fixed(dq_pkg::REQ_POP_BACK, VAL_MAX,
              mk_res(NONE_MARK, 1'b1, 1'b0, 0, 1'b1, NONE_MARK, NONE_MARK));
    add_fixed(dq_pkg::REQ_QUERY + dq_pkg::req_t'(1), VAL_MIN,
              mk_res(NONE_MARK, 1'b0, 1'b0, 0, 1'b1, NONE_MARK, NONE_MARK));
    // extreme values at both ends
    add_fixed(dq_pkg::REQ_PUSH_BACK, VAL_MAX,
              mk_res(NONE_MARK, 1'b0, 1'b0, 1, 1'b0, VAL_MAX, VAL_MAX));
    add_fixed(dq_pkg::REQ_PUSH_FRONT, VAL_MIN,
              mk_res(NONE_MARK, 1'b0, 1'b0, 2, 1'b0, VAL_MIN, VAL_MAX));
    add_fixed(dq_pkg::REQ_QUERY, 32'sd1,
              mk_res(NONE_MARK, 1'b0, 1'b0, 2, 1'b0, VAL_MIN, VAL_MAX));
    add_row(dq_pkg::REQ_QUERY + dq_pkg::req_t'(2), 32'sd0);
    add_row(dq_pkg::REQ_QUERY + dq_pkg::req_t'(3), NONE_MARK);
    add_fixed(dq_pkg::REQ_POP_BACK, 32'sd0,
              mk_res(VAL_MAX, 1'b0, 1'b0, 1, 1'b0, VAL_MIN, VAL_MIN));
    // pop of the last entry
    add_fixed(dq_pkg::REQ_POP_FRONT, 32'sd0,
              mk_res(VAL_MIN, 1'b0, 1'b0, 0, 1'b1, NONE_MARK, NONE_MARK));
    // pushes and pops that leave entries behind
    add_row(dq_pkg::REQ_PUSH_FRONT, NONE_MARK);
    add_row(dq_pkg::REQ_PUSH_BACK, 32'sd0);
    add_row(dq_pkg::REQ_PUSH_FRONT, 32'sd1);
    add_row(dq_pkg::REQ_PUSH_BACK, 32'sh55555555);
    add_row(dq_pkg::REQ_PUSH_FRONT, 32'shaaaaaaaa);
    add_row(dq_pkg::REQ_POP_FRONT, 32'shdeadbeef);
    add_row(dq_pkg::REQ_POP_BACK, 32'sd0);
    add_row(dq_pkg::REQ_PUSH_BACK, 32'sd123);
    add_row(dq_pkg::REQ_POP_BACK, 32'sd0);
    add_row(dq_pkg::REQ_POP_FRONT, 32'sd0);
    add_row(dq_pkg::REQ_POP_FRONT, 32'sd0);
    add_row(dq_pkg::REQ_POP_BACK, 32'sd0);
    add_row(dq_pkg::REQ_POP_BACK, 32'sd0);
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // mixed traffic around a small fill level
    for (k = 0; k < 40; k++) send_rand(45, 40);

    // long receiver hold while items keep coming, then a full drain
    hold_reqs <= hold_reqs + 1;
    no_gaps = 1'b1;
    for (k = 0; k < 40; k++) send_rand(60, 20);
    no_gaps = 1'b0;
    wait_drained();

    // fill the ring, wrapping both indices
    while (fill_cnt < CAPACITY) send_rand(99, 1);
    // pushes into a full ring at both ends, queries while full
    for (k = 0; k < 8; k++) send_rand(100, 0);
    send_rand(0, 0);
    send_rand(0, 0);
    // pop and refill at the full boundary
    for (k = 0; k < 30; k++) send_rand(50, 50);

    // second hold while near full
    hold_reqs <= hold_reqs + 1;
    no_gaps = 1'b1;
    for (k = 0; k < 30; k++) send_rand(50, 40);
    no_gaps = 1'b0;

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: long holds on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_taken) begin
      hold_taken <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode <= rx_mode_t'($urandom_range(3));
        pat_left <= $urandom_range(5, 80);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (pat_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= $urandom_range(1);
        RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  function automatic int field_bad(input string name, input longint exp_v,
                                   input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // compare each result item with the oldest prediction
  always @(posedge clk) begin : result_check
    dq_result_t exp_res;
    int         bad;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result item with no prediction waiting", $time);
        errors <= errors + 1;
      end else begin
        exp_res = pending_q[0];
        pending_q.delete(0);
        bad = 0;
        bad += field_bad("popped_value", exp_res.popped, out_popped_value);
        bad += field_bad("pop_was_empty", exp_res.pop_empty, out_pop_was_empty);
        bad += field_bad("push_dropped", exp_res.dropped, out_push_dropped);
        bad += field_bad("entry_count", exp_res.count, out_entry_count);
        bad += field_bad("is_empty", exp_res.empty, out_is_empty);
        bad += field_bad("front_value", exp_res.front, out_front_value);
        bad += field_bad("back_value", exp_res.back, out_back_value);
        if (bad != 0) errors <= errors + 1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

/* double_ended_queue.f */
design/dq_pkg.sv
design/dq_ram.sv
design/double_ended_queue.sv
tb/tb_top.sv
